[rtl/u16550_pkg.sv]
// shared types and constants for the 16550 register core
package u16550_pkg;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_STATUS = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_RBR_THR = 3'd0,
    REG_IER     = 3'd1,
    REG_IIR     = 3'd2,
    REG_LCR     = 3'd3,
    REG_MCR     = 3'd4,
    REG_LSR     = 3'd5,
    REG_MSR     = 3'd6,
    REG_SCR     = 3'd7
  } reg_addr_t;

  typedef struct packed {
    op_t         op;
    reg_addr_t   reg_addr;
    logic [7:0]  write_data;
    logic        rx_ready;
    logic        tx_ready;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rx_pop;
    logic        tx_push;
    logic [7:0]  tx_byte;
    logic        irq;
  } out_item_t;

  localparam int unsigned DLAB_IDX   = 7;
  localparam int unsigned IER_RX_IDX = 0;
  localparam int unsigned IER_TX_IDX = 1;
  localparam int unsigned FLAG_RX    = 0;
  localparam int unsigned FLAG_TX    = 1;

  localparam logic [7:0] IIR_FIFO  = 8'hC0;
  localparam logic [7:0] IIR_NONE  = 8'h01;
  localparam logic [7:0] IIR_TX    = 8'h02;
  localparam logic [7:0] IIR_RX    = 8'h04;
  localparam logic [7:0] LSR_RX    = 8'h01;
  localparam logic [7:0] LSR_TX    = 8'h60;
  localparam logic [7:0] MSR_FIXED = 8'hB0;

endpackage

[rtl/uart_16550_register_core_top.sv]
// 16550-style register file: bus reads and writes plus backend status updates
//
// Each input word is a register read, a register write or a backend status
// update, carrying the backend's live receive and transmit readiness. One word
// is taken per clock unless the output register is stalled, and its result word
// appears in the next cycle from that register; the only limit on rate is that
// output register, which is refilled in the same cycle it is drained, so a full
// stream runs at one word per cycle while out_ready is high. Receive readiness
// is hidden until IER bit 0 has been written as one. A pop or push does not
// change the stored flags by itself: the backend reports its new state with a
// following status word. irq reflects the stored flags and IER after the word.
module uart_16550_register_core_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  u16550_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output u16550_pkg::out_item_t out_data
);
  import u16550_pkg::*;

  logic [7:0] ier_r, ier_nxt;
  logic [7:0] lcr_r, lcr_nxt;
  logic [7:0] mcr_r, mcr_nxt;
  logic [7:0] scr_r, scr_nxt;
  logic [7:0] dll_r, dll_nxt;
  logic [7:0] dlm_r, dlm_nxt;
  logic       rx_armed_r, rx_armed_nxt;
  logic [1:0] flags_r, flags_nxt;

  logic       out_valid_r;
  out_item_t  out_r, out_nxt;

  logic       accept;
  logic       dlab;
  logic [1:0] vis;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign dlab          = lcr_r[DLAB_IDX];
  assign vis[FLAG_RX]  = in_data.rx_ready && rx_armed_r;
  assign vis[FLAG_TX]  = in_data.tx_ready;

  always_comb begin
    ier_nxt      = ier_r;
    lcr_nxt      = lcr_r;
    mcr_nxt      = mcr_r;
    scr_nxt      = scr_r;
    dll_nxt      = dll_r;
    dlm_nxt      = dlm_r;
    rx_armed_nxt = rx_armed_r;
    flags_nxt    = flags_r;
    out_nxt      = '0;

    unique case (in_data.op)
      OP_READ: begin
        unique case (in_data.reg_addr)
          REG_RBR_THR: begin
            if (dlab) begin
              out_nxt.read_data = dll_r;
            end else if (vis[FLAG_RX]) begin
              out_nxt.read_data = in_data.rx_byte;
              out_nxt.rx_pop    = 1'b1;
            end
          end
          REG_IER: out_nxt.read_data = dlab ? dlm_r : ier_r;
          REG_IIR: begin
            priority if (vis[FLAG_RX] && ier_r[IER_RX_IDX]) begin
              out_nxt.read_data = IIR_FIFO | IIR_RX;
            end else if (vis[FLAG_TX] && ier_r[IER_TX_IDX]) begin
              out_nxt.read_data = IIR_FIFO | IIR_TX;
            end else begin
              out_nxt.read_data = IIR_FIFO | IIR_NONE;
            end
          end
          REG_LCR: out_nxt.read_data = lcr_r;
          REG_MCR: out_nxt.read_data = mcr_r;
          REG_LSR: out_nxt.read_data = (vis[FLAG_RX] ? LSR_RX : 8'h00) |
                                       (vis[FLAG_TX] ? LSR_TX : 8'h00);
          REG_MSR: out_nxt.read_data = MSR_FIXED;
          REG_SCR: out_nxt.read_data = scr_r;
          default: out_nxt.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (in_data.reg_addr)
          REG_RBR_THR: begin
            if (dlab) begin
              dll_nxt = in_data.write_data;
            end else begin
              out_nxt.tx_push = 1'b1;
              out_nxt.tx_byte = in_data.write_data;
            end
          end
          REG_IER: begin
            if (dlab) begin
              dlm_nxt = in_data.write_data;
            end else begin
              ier_nxt = in_data.write_data;
              // arming makes receive readiness visible right away
              if (in_data.write_data[IER_RX_IDX]) begin
                rx_armed_nxt       = 1'b1;
                flags_nxt[FLAG_RX] = in_data.rx_ready;
                flags_nxt[FLAG_TX] = in_data.tx_ready;
              end
            end
          end
          REG_LCR: lcr_nxt = in_data.write_data;
          REG_MCR: mcr_nxt = in_data.write_data;
          REG_SCR: scr_nxt = in_data.write_data;
          default: ;
        endcase
      end
      OP_STATUS: flags_nxt = vis;
      default: ;
    endcase

    out_nxt.irq = (flags_nxt[FLAG_RX] && ier_nxt[IER_RX_IDX]) ||
                  (flags_nxt[FLAG_TX] && ier_nxt[IER_TX_IDX]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ier_r       <= '0;
      lcr_r       <= '0;
      mcr_r       <= '0;
      scr_r       <= '0;
      dll_r       <= '0;
      dlm_r       <= '0;
      rx_armed_r  <= 1'b0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        ier_r      <= ier_nxt;
        lcr_r      <= lcr_nxt;
        mcr_r      <= mcr_nxt;
        scr_r      <= scr_nxt;
        dll_r      <= dll_nxt;
        dlm_r      <= dlm_nxt;
        rx_armed_r <= rx_armed_nxt;
        flags_r    <= flags_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

endmodule

[rtl/u16550_chk.sv]
// port-level checks for the 16550 register core, bound to the top level
module u16550_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input u16550_pkg::out_item_t out_data
);
  import u16550_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // every accepted word yields a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  a_pop_push_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.rx_pop && out_data.tx_push))
    else $error("pop and push in one result");

  a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_push |-> out_data.tx_byte == 8'h00)
    else $error("tx byte set without push");

  a_push_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tx_push |-> out_data.read_data == 8'h00)
    else $error("read data set on a push");

endmodule

bind uart_16550_register_core_top u16550_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/uart_16550_register_core_top_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for the 16550 register core: directed table, then random words
module uart_16550_register_core_top_test;
  import u16550_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_WORDS = 500;

  typedef struct {
    in_item_t  w;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // register file mirror
  logic [7:0] ier_q      = '0;
  logic [7:0] lcr_q      = '0;
  logic [7:0] mcr_q      = '0;
  logic [7:0] scr_q      = '0;
  logic [7:0] dll_q      = '0;
  logic [7:0] dlm_q      = '0;
  logic       rx_armed_q = 1'b0;
  logic [1:0] flags_q    = '0;

  out_item_t   pending_results[$];
  row_t        script[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          hold_req   = 1'b0;
  bit          quiet_rx   = 1'b0;

  always #5 clk = ~clk;

  uart_16550_register_core_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic out_item_t regfile_predict(in_item_t w);
    logic      vis_rx;
    logic      vis_tx;
    logic      dlab;
    out_item_t r;
    vis_rx = w.rx_ready & rx_armed_q;
    vis_tx = w.tx_ready;
    dlab   = lcr_q[DLAB_IDX];
    r      = '0;
    case (w.op)
      OP_READ: begin
        case (w.reg_addr)
          REG_RBR_THR: begin
            if (dlab) begin
              r.read_data = dll_q;
            end else if (vis_rx) begin
              r.read_data = w.rx_byte;
              r.rx_pop    = 1'b1;
            end
          end
          REG_IER: r.read_data = dlab ? dlm_q : ier_q;
          REG_IIR: begin
            // receive outranks transmit
            if (vis_rx && ier_q[IER_RX_IDX]) begin
              r.read_data = IIR_FIFO | IIR_RX;
            end else if (vis_tx && ier_q[IER_TX_IDX]) begin
              r.read_data = IIR_FIFO | IIR_TX;
            end else begin
              r.read_data = IIR_FIFO | IIR_NONE;
            end
          end
          REG_LCR: r.read_data = lcr_q;
          REG_MCR: r.read_data = mcr_q;
          REG_LSR: r.read_data = (vis_rx ? LSR_RX : 8'h00) | (vis_tx ? LSR_TX : 8'h00);
          REG_MSR: r.read_data = MSR_FIXED;
          default: r.read_data = scr_q;
        endcase
      end
      OP_WRITE: begin
        case (w.reg_addr)
          REG_RBR_THR: begin
            if (dlab) begin
              dll_q = w.write_data;
            end else begin
              r.tx_push = 1'b1;
              r.tx_byte = w.write_data;
            end
          end
          REG_IER: begin
            if (dlab) begin
              dlm_q = w.write_data;
            end else begin
              ier_q = w.write_data;
              if (w.write_data[IER_RX_IDX]) begin
                // arming makes live receive readiness visible at once
                rx_armed_q       = 1'b1;
                flags_q[FLAG_RX] = w.rx_ready;
                flags_q[FLAG_TX] = vis_tx;
              end
            end
          end
          REG_LCR: lcr_q = w.write_data;
          REG_MCR: mcr_q = w.write_data;
          REG_SCR: scr_q = w.write_data;
          default: ;
        endcase
      end
      OP_STATUS: begin
        flags_q[FLAG_RX] = vis_rx;
        flags_q[FLAG_TX] = vis_tx;
      end
      default: ;
    endcase
    r.irq = (flags_q[FLAG_RX] & ier_q[IER_RX_IDX]) | (flags_q[FLAG_TX] & ier_q[IER_TX_IDX]);
    return r;
  endfunction

  function automatic in_item_t word(op_t op, reg_addr_t a, logic [7:0] d, logic rxr, logic txr,
                                    logic [7:0] rb);
    in_item_t w;
    w.op         = op;
    w.reg_addr   = a;
    w.write_data = d;
    w.rx_ready   = rxr;
    w.tx_ready   = txr;
    w.rx_byte    = rb;
    return w;
  endfunction

  function automatic out_item_t res(logic [7:0] rd, logic pop, logic push, logic [7:0] tb,
                                    logic irq);
    out_item_t r;
    r.read_data = rd;
    r.rx_pop    = pop;
    r.tx_push   = push;
    r.tx_byte   = tb;
    r.irq       = irq;
    return r;
  endfunction

  function automatic row_t row(in_item_t w, bit typed, out_item_t want);
    row_t r;
    r.w     = w;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic in_item_t rand_word();
    int unsigned k;
    op_t         op;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      op = OP_READ;
    end else if (k < 75) begin
      op = OP_WRITE;
    end else if (k < 95) begin
      op = OP_STATUS;
    end else begin
      op = OP_RSVD;
    end
    return word(op, reg_addr_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endfunction

  task automatic cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %02h, got %02h", $time, name, want, got);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result word: expected none, got %h", $time, got);
    end else begin
      want = pending_results.pop_front();
      cmp_field("read_data", want.read_data, got.read_data);
      cmp_field("rx_pop", 8'(want.rx_pop), 8'(got.rx_pop));
      cmp_field("tx_push", 8'(want.tx_push), 8'(got.tx_push));
      cmp_field("tx_byte", want.tx_byte, got.tx_byte);
      cmp_field("irq", 8'(want.irq), 8'(got.irq));
    end
  endtask

  task automatic send_word(in_item_t w, bit typed, out_item_t want);
    out_item_t guess;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = regfile_predict(w);
    pending_results.push_back(typed ? want : guess);
  endtask

  task automatic maybe_idle(bit quiet);
    if (!quiet && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side: random backpressure, one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_result(out_data);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
        out_ready <= 1'b0;
      end else if (quiet_rx) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("uart_16550_register_core_top_test: errors");
      $finish;
    end
  end

  initial begin
    in_item_t w;
    bit       quiet;

    // fixed answers right after reset
    script.push_back(row(word(OP_READ, REG_MSR, 8'h00, 1, 1, 8'h00), 1,
                         res(MSR_FIXED, 0, 0, 8'h00, 0)));
    script.push_back(row(word(OP_READ, REG_IIR, 8'hFF, 1, 1, 8'hFF), 1,
                         res(IIR_FIFO | IIR_NONE, 0, 0, 8'h00, 0)));
    // receive not armed yet: hidden from lsr and rbr
    script.push_back(row(word(OP_READ, REG_LSR, 8'h00, 1, 1, 8'h00), 1,
                         res(LSR_TX, 0, 0, 8'h00, 0)));
    script.push_back(row(word(OP_READ, REG_RBR_THR, 8'h00, 1, 1, 8'h5A), 1,
                         res(8'h00, 0, 0, 8'h00, 0)));
    // push goes out even with the backend not ready
    script.push_back(row(word(OP_WRITE, REG_RBR_THR, 8'hFF, 0, 0, 8'h00), 1,
                         res(8'h00, 0, 1, 8'hFF, 0)));
    script.push_back(row(word(OP_WRITE, REG_IIR, 8'hFF, 1, 1, 8'hFF), 1, '0));
    script.push_back(row(word(OP_WRITE, REG_LSR, 8'hFF, 1, 1, 8'hFF), 1, '0));
    script.push_back(row(word(OP_RSVD, REG_SCR, 8'hFF, 1, 1, 8'hFF), 1, '0));
    script.push_back(row(word(OP_STATUS, REG_RBR_THR, 8'h00, 1, 1, 8'h00), 1, '0));
    script.push_back(row(word(OP_WRITE, REG_IER, 8'h03, 1, 1, 8'h00), 1,
                         res(8'h00, 0, 0, 8'h00, 1)));
    script.push_back(row(word(OP_READ, REG_IIR, 8'h00, 1, 1, 8'h00), 0, '0));
    script.push_back(row(word(OP_READ, REG_RBR_THR, 8'h00, 1, 1, 8'hA5), 0, '0));
    script.push_back(row(word(OP_STATUS, REG_RBR_THR, 8'h00, 0, 1, 8'h00), 0, '0));
    script.push_back(row(word(OP_READ, REG_IIR, 8'h00, 0, 1, 8'h00), 0, '0));
    script.push_back(row(word(OP_READ, REG_LSR, 8'h00, 1, 1, 8'h00), 0, '0));
    script.push_back(row(word(OP_WRITE, REG_LCR, 8'h80, 0, 0, 8'h00), 0, '0));
    script.push_back(row(word(OP_WRITE, REG_RBR_THR, 8'hFF, 0, 0, 8'h00), 0, '0));
    script.push_back(row(word(OP_WRITE, REG_IER, 8'h01, 1, 0, 8'h00), 0, '0));
    script.push_back(row(word(OP_READ, REG_RBR_THR, 8'h00, 1, 1, 8'h33), 0, '0));
    script.push_back(row(word(OP_READ, REG_IER, 8'h00, 1, 1, 8'h00), 0, '0));
    script.push_back(row(word(OP_WRITE, REG_LCR, 8'h7F, 0, 0, 8'h00), 0, '0));
    script.push_back(row(word(OP_READ, REG_LCR, 8'h00, 0, 0, 8'h00), 0, '0));
    script.push_back(row(word(OP_WRITE, REG_MCR, 8'hFF, 0, 0, 8'h00), 0, '0));
    script.push_back(row(word(OP_WRITE, REG_SCR, 8'hFF, 0, 0, 8'h00), 0, '0));
    script.push_back(row(word(OP_READ, REG_SCR, 8'h00, 0, 0, 8'h00), 0, '0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      send_word(script[i].w, script[i].typed, script[i].want);
      maybe_idle(1'b0);
    end
    drain();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      quiet    = (i >= 200 && i < 320);
      quiet_rx = quiet;
      if (i == 240) hold_req = 1'b1;
      if (i == 120) drain();
      w = rand_word();
      send_word(w, 1'b0, '0);
      // backend reports its new state after a pop or push most of the time
      if ((w.op == OP_READ || w.op == OP_WRITE) && w.reg_addr == REG_RBR_THR &&
          $urandom_range(0, 99) < 60) begin
        send_word(word(OP_STATUS, reg_addr_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       8'($urandom_range(0, 255))), 1'b0, '0);
      end
      maybe_idle(quiet);
    end

    drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("uart_16550_register_core_top_test: clean");
    end else begin
      $display("uart_16550_register_core_top_test: errors");
    end
    $finish;
  end

endmodule
